FILE: rtl/u8ci_pkg.sv
`timescale 1ns / 1ps

package u8ci_pkg;

    // Field widths of the two channels
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 32;
    localparam int CODE_W  = 21;
    localparam int COUNT_W = 32;

    // Default width of the internal character counter
    localparam int COUNT_BITS_DEF = 32;

    // Lead byte thresholds
    localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;

    // Payload masks
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;

    // Continuation bytes still due after a lead byte
    localparam logic [1:0] LEFT_NONE  = 2'd0;
    localparam logic [1:0] LEFT_ONE   = 2'd1;
    localparam logic [1:0] LEFT_TWO   = 2'd2;
    localparam logic [1:0] LEFT_THREE = 2'd3;

    typedef struct packed {
        logic              found;
        logic [CODE_W-1:0] code_point;
        logic [COUNT_W-1:0] char_count;
    } t_result;

endpackage

FILE: rtl/u8ci_if.sv
`timescale 1ns / 1ps

// String byte channel
interface u8ci_in_if;
    logic                          valid;
    logic                          ready;
    logic [u8ci_pkg::BYTE_W-1:0]   data_byte;
    logic                          has_byte;
    logic                          last_item;
    logic [u8ci_pkg::INDEX_W-1:0]  wanted_index;

    modport source (output valid, data_byte, has_byte, last_item, wanted_index,
                    input ready);
    modport sink   (input valid, data_byte, has_byte, last_item, wanted_index,
                    output ready);
endinterface

// Lookup result channel
interface u8ci_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [u8ci_pkg::CODE_W-1:0]   code_point;
    logic [u8ci_pkg::COUNT_W-1:0]  char_count;

    modport source (output valid, found, code_point, char_count, input ready);
    modport sink   (input valid, found, code_point, char_count, output ready);
endinterface

FILE: rtl/utf8_char_index_decoder.sv
`timescale 1ns / 1ps

// Channel   Dir  Beat                                         Payload
// i_in      in   one string byte (or empty-string marker)     data_byte, has_byte,
//                                                             last_item, wanted_index
// o_out     out  one lookup result per string                 found, code_point,
//                                                             char_count
//
// One byte per clock while i_in.ready is high. Each beat updates the decode
// state in the cycle it is accepted; a string's result shows on o_out the
// cycle after its last beat when the buffer is empty. A two-entry output
// buffer (head + skid) lets the input keep flowing while a result waits;
// i_in.ready drops only when both are full. Reset (i_rst_n low, sync)
// empties the buffer and arms the start-of-string flag; no clearing pass.

module utf8_char_index_decoder #(
    parameter int COUNT_BITS = u8ci_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    u8ci_in_if.sink           i_in,
    u8ci_out_if.source        o_out
);

    // Compare width: covers both the counter and the wanted index
    localparam int CMP_W = (COUNT_BITS > u8ci_pkg::INDEX_W) ? COUNT_BITS
                                                            : u8ci_pkg::INDEX_W;

    // Per-string decode state
    logic                              r_start;
    logic [u8ci_pkg::INDEX_W-1:0]      r_target;
    logic [COUNT_BITS-1:0]             r_seen;
    logic [1:0]                        r_left;
    logic [u8ci_pkg::CODE_W-1:0]       r_partial;
    logic                              r_hit;
    logic [u8ci_pkg::CODE_W-1:0]       r_hit_point;
    logic                              r_tracking;

    logic                              n_start;
    logic [u8ci_pkg::INDEX_W-1:0]      n_target;
    logic [COUNT_BITS-1:0]             n_seen;
    logic [1:0]                        n_left;
    logic [u8ci_pkg::CODE_W-1:0]       n_partial;
    logic                              n_hit;
    logic [u8ci_pkg::CODE_W-1:0]       n_hit_point;
    logic                              n_tracking;

    // Output buffer: head register plus skid
    logic                              r_out_valid;
    u8ci_pkg::t_result                 r_out;
    logic                              r_skid_valid;
    u8ci_pkg::t_result                 r_skid;

    u8ci_pkg::t_result                 n_result;

    logic                              in_accept;
    logic                              push;
    logic                              pop;

    assign in_accept = i_in.valid && i_in.ready;
    assign push      = in_accept && i_in.last_item;
    assign pop       = r_out_valid && o_out.ready;

    // Decode one beat
    always_comb begin
        logic [u8ci_pkg::BYTE_W-1:0]  c;
        logic [u8ci_pkg::CODE_W-1:0]  cont_bits;
        logic [1:0]                   left_dec;

        c         = i_in.data_byte;
        cont_bits = '0;
        left_dec  = r_left - 2'd1;

        // A new string drops whatever the previous one left behind
        n_start     = r_start;
        n_target    = r_start ? i_in.wanted_index : r_target;
        n_seen      = r_start ? '0 : r_seen;
        n_left      = r_start ? u8ci_pkg::LEFT_NONE : r_left;
        n_partial   = r_start ? '0 : r_partial;
        n_hit       = r_start ? 1'b0 : r_hit;
        n_hit_point = r_start ? '0 : r_hit_point;
        n_tracking  = r_start ? 1'b0 : r_tracking;

        if (in_accept && i_in.has_byte) begin
            if (n_left == u8ci_pkg::LEFT_NONE) begin
                // Lead byte: width from its top bits; stray continuation acts as 2-byte lead
                if (c < u8ci_pkg::LEAD2_MIN) begin
                    n_partial = u8ci_pkg::CODE_W'(c);
                    n_left    = u8ci_pkg::LEFT_NONE;
                end else if (c < u8ci_pkg::LEAD3_MIN) begin
                    n_partial = u8ci_pkg::CODE_W'(c & u8ci_pkg::LEAD2_MASK) << 6;
                    n_left    = u8ci_pkg::LEFT_ONE;
                end else if (c < u8ci_pkg::LEAD4_MIN) begin
                    n_partial = u8ci_pkg::CODE_W'(c & u8ci_pkg::LEAD3_MASK) << 12;
                    n_left    = u8ci_pkg::LEFT_TWO;
                end else begin
                    n_partial = u8ci_pkg::CODE_W'(c & u8ci_pkg::LEAD4_MASK) << 18;
                    n_left    = u8ci_pkg::LEFT_THREE;
                end

                // Only the first character numbered as the target is kept
                if (!n_hit && (CMP_W'(n_seen) == CMP_W'(n_target))) begin
                    n_hit       = 1'b1;
                    n_tracking  = 1'b1;
                    n_hit_point = n_partial;
                end else begin
                    n_tracking  = 1'b0;
                end

                // Saturating character count
                if (n_seen != {COUNT_BITS{1'b1}}) begin
                    n_seen = n_seen + COUNT_BITS'(1);
                end
            end else begin
                // Continuation byte, unchecked; lands 6 bits per remaining slot
                case (left_dec)
                    u8ci_pkg::LEFT_NONE:
                        cont_bits = u8ci_pkg::CODE_W'(c & u8ci_pkg::CONT_MASK);
                    u8ci_pkg::LEFT_ONE:
                        cont_bits = u8ci_pkg::CODE_W'(c & u8ci_pkg::CONT_MASK) << 6;
                    u8ci_pkg::LEFT_TWO:
                        cont_bits = u8ci_pkg::CODE_W'(c & u8ci_pkg::CONT_MASK) << 12;
                    default:
                        cont_bits = u8ci_pkg::CODE_W'(c & u8ci_pkg::CONT_MASK) << 18;
                endcase
                n_left    = left_dec;
                n_partial = n_partial | cont_bits;
                if (n_tracking) begin
                    n_hit_point = n_partial;
                end
            end
        end

        if (in_accept) begin
            n_start = i_in.last_item;
        end

        // Result for the closing beat
        n_result.found      = n_hit;
        n_result.code_point = n_hit ? n_hit_point : '0;
        if (CMP_W'(n_seen) > CMP_W'({u8ci_pkg::COUNT_W{1'b1}})) begin
            n_result.char_count = {u8ci_pkg::COUNT_W{1'b1}};
        end else begin
            n_result.char_count = u8ci_pkg::COUNT_W'(n_seen);
        end
    end

    // Decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= 1'b1;
            r_left     <= u8ci_pkg::LEFT_NONE;
            r_hit      <= 1'b0;
            r_tracking <= 1'b0;
        end else if (in_accept) begin
            r_start    <= n_start;
            r_left     <= n_left;
            r_hit      <= n_hit;
            r_tracking <= n_tracking;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_target    <= n_target;
            r_seen      <= n_seen;
            r_partial   <= n_partial;
            r_hit_point <= n_hit_point;
        end
    end

    // Output buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (push) begin
                if (!r_out_valid || (pop && !r_skid_valid)) begin
                    r_out_valid <= 1'b1;
                end else if (!pop) begin
                    r_skid_valid <= 1'b1;
                end
            end else if (pop) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // Output buffer data
    always_ff @(posedge i_clk) begin
        if (push) begin
            if (!r_out_valid || (pop && !r_skid_valid)) begin
                r_out <= n_result;
            end else if (!pop) begin
                r_skid <= n_result;
            end
        end else if (pop && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    // Ready stays up until the skid is occupied
    assign i_in.ready       = !r_skid_valid;
    assign o_out.valid      = r_out_valid;
    assign o_out.found      = r_out.found;
    assign o_out.code_point = r_out.code_point;
    assign o_out.char_count = r_out.char_count;

    // Skid never holds a beat while the head is empty
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid valid with empty head");

    // A miss never carries a code point
    a_miss_zero_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |-> (o_out.code_point == '0))
        else $error("code point set on a miss");

    // Closing beat re-arms the start of the next string
    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.last_item) |=> r_start)
        else $error("start flag not set after last beat");

    // Tracking only follows a recorded hit
    a_track_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tracking |-> r_hit)
        else $error("tracking without a hit");

    // A result into an empty buffer shows next cycle
    a_result_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !r_out_valid) |=> o_out.valid)
        else $error("result lost on empty buffer");

endmodule

FILE: sim/u8ci_checker.sv
`timescale 1ns / 1ps

module u8ci_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    u8ci_in_if   i_in,
    u8ci_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);
    import u8ci_pkg::*;

    localparam logic [63:0] SEEN_MAX = (COUNT_BITS_DEF >= 64) ? '1 :
                                       ((64'd1 << COUNT_BITS_DEF) - 64'd1);

    // Decoder mirror
    logic               string_start;
    logic [INDEX_W-1:0] target;
    logic [63:0]        seen;
    logic [1:0]         left;
    logic [CODE_W-1:0]  partial;
    logic               hit;
    logic [CODE_W-1:0]  hit_cp;
    logic               tracking;

    t_result lookup_q[$];
    int      mismatches = 0;
    int      waiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    task clear_string();
        seen     = '0;
        left     = LEFT_NONE;
        partial  = '0;
        hit      = 1'b0;
        hit_cp   = '0;
        tracking = 1'b0;
    endtask

    task decode_byte(input logic [BYTE_W-1:0] c);
        if (left == LEFT_NONE) begin
            if (c < LEAD2_MIN) begin
                partial = CODE_W'(c);
                left    = LEFT_NONE;
            end else if (c < LEAD3_MIN) begin
                partial = CODE_W'(c & LEAD2_MASK) << 6;
                left    = LEFT_ONE;
            end else if (c < LEAD4_MIN) begin
                partial = CODE_W'(c & LEAD3_MASK) << 12;
                left    = LEFT_TWO;
            end else begin
                partial = CODE_W'(c & LEAD4_MASK) << 18;
                left    = LEFT_THREE;
            end
            // only the first character at the wanted number is kept
            if (!hit && seen == 64'(target)) begin
                hit      = 1'b1;
                tracking = 1'b1;
                hit_cp   = partial;
            end else begin
                tracking = 1'b0;
            end
            if (seen < SEEN_MAX)
                seen = seen + 64'd1;
        end else begin
            left    = left - 2'd1;
            partial = partial | (CODE_W'(c & CONT_MASK) << (6 * left));
            if (tracking)
                hit_cp = partial;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            string_start = 1'b1;
            target       = '0;
            clear_string();
            lookup_q.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                if (string_start) begin
                    target = i_in.wanted_index;
                    clear_string();
                    string_start = 1'b0;
                end
                if (i_in.has_byte)
                    decode_byte(i_in.data_byte);
                if (i_in.last_item) begin
                    want.found      = hit;
                    want.code_point = hit ? hit_cp : '0;
                    want.char_count = (seen > 64'hFFFF_FFFF) ? '1 : seen[COUNT_W-1:0];
                    lookup_q.push_back(want);
                    string_start = 1'b1;
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (lookup_q.size() == 0) begin
                    $error("unexpected result beat: found %0d code_point %0h char_count %0d",
                           i_out.found, i_out.code_point, i_out.char_count);
                    mismatches++;
                end else begin
                    want = lookup_q.pop_front();
                    if (i_out.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, i_out.found);
                        mismatches++;
                    end
                    if (i_out.code_point !== want.code_point) begin
                        $error("code_point: expected %0h, got %0h",
                               want.code_point, i_out.code_point);
                        mismatches++;
                    end
                    if (i_out.char_count !== want.char_count) begin
                        $error("char_count: expected %0d, got %0d",
                               want.char_count, i_out.char_count);
                        mismatches++;
                    end
                end
            end
        end
        waiting = lookup_q.size();
    end

endmodule

FILE: sim/tb_utf8_char_index_decoder.sv
`timescale 1ns / 1ps

module tb_utf8_char_index_decoder;
    import u8ci_pkg::*;

    localparam int BEAT_TARGET  = 1100;   // input beats before the random part stops
    localparam int CALM_AFTER   = 900;    // no idling on either side past this point
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    // A string symbol is 9 bits: bit 8 set means a beat with has_byte low
    // (payload byte is then random junk the block must ignore).
    localparam logic [8:0] NO_BYTE = 9'h100;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int fail_count;
    int pending;
    int beats_sent  = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    bit jitter_on   = 1'b1;

    logic [8:0] str_bytes[$];

    u8ci_in_if  in_ch ();
    u8ci_out_if out_ch ();

    utf8_char_index_decoder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Watches both channels, predicts every lookup and scores the results
    u8ci_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 clk = ~clk;

    // Hard stop in case the handshake locks up
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: ready drops in random bursts while jitter is on,
    // otherwise it stays high. Changes on the falling edge.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ch.ready = 1'b0;
        end else if (jitter_on && $urandom_range(0, 11) == 0) begin
            stall_left   = $urandom_range(1, 17) - 1;
            out_ch.ready = 1'b0;
        end else begin
            out_ch.ready = 1'b1;
        end
    end

    // One input beat. Optionally preceded by an idle burst (valid low),
    // then held until the block takes it at a rising edge. Returns on the
    // following falling edge so the next beat can follow back to back.
    task automatic send_beat(input logic [8:0] sym, input logic lst,
                             input logic [INDEX_W-1:0] idx);
        int gap;
        if (jitter_on && $urandom_range(0, 9) == 0) begin
            in_ch.valid = 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.has_byte     = !sym[8];
        in_ch.data_byte    = sym[8] ? 8'($urandom()) : sym[7:0];
        in_ch.last_item    = lst;
        in_ch.wanted_index = idx;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    // Sends str_bytes as one string. The index only matters on the first
    // beat; later beats carry random indexes to show they are ignored.
    task automatic send_string(input logic [INDEX_W-1:0] idx);
        for (int k = 0; k < str_bytes.size(); k++)
            send_beat(str_bytes[k], k == str_bytes.size() - 1,
                      (k == 0) ? idx : INDEX_W'($urandom()));
    endtask

    initial begin
        logic [INDEX_W-1:0] idx;
        logic [7:0]         lead;
        int                 kind;
        int                 nchars;
        int                 width;
        int                 drop;

        in_ch.valid        = 1'b0;
        in_ch.data_byte    = '0;
        in_ch.has_byte     = 1'b0;
        in_ch.last_item    = 1'b0;
        in_ch.wanted_index = '0;
        out_ch.ready       = 1'b0;

        // Sync reset held low from time zero, released on a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- Directed strings ----
        // empty string: no byte, last beat only
        str_bytes = '{NO_BYTE};
        send_string(0);
        // ASCII extremes, wanted char is the NUL
        str_bytes = '{9'h07F, 9'h000};
        send_string(1);
        // largest 2-, 3- and 4-byte code points
        str_bytes = '{9'h0DF, 9'h0BF};
        send_string(0);
        str_bytes = '{9'h0EF, 9'h0BF, 9'h0BF};
        send_string(0);
        str_bytes = '{9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF};
        send_string(0);
        // stray continuation taken as a lead, then a 4-byte lead 0xFF
        // cut off at the end of the string
        str_bytes = '{9'h080, 9'h0BF, 9'h0FF};
        send_string(1);
        // byte-less beats mid-string and as the closing beat, with the
        // wanted 3-byte char truncated
        str_bytes = '{9'h041, NO_BYTE, 9'h0E2, 9'h082, NO_BYTE};
        send_string(1);
        // index far past the end, and just past the end
        str_bytes = '{9'h041};
        send_string('1);
        str_bytes = '{9'h041, 9'h042};
        send_string(2);

        // Hold off until every lookup so far has come back
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);

        // ---- Random strings ----
        // Mostly well-formed UTF-8 with random content, some raw byte noise,
        // some empty strings, truncations and byte-less beats.
        while (beats_sent < BEAT_TARGET) begin
            if (beats_sent >= CALM_AFTER)
                jitter_on = 1'b0;
            str_bytes.delete();
            kind = $urandom_range(0, 99);
            if (kind < 3) begin
                str_bytes.push_back(NO_BYTE);
                nchars = 0;
            end else if (kind < 12) begin
                nchars = $urandom_range(1, 10);
                repeat (nchars) begin
                    if ($urandom_range(0, 7) == 0)
                        str_bytes.push_back(NO_BYTE);
                    else
                        str_bytes.push_back(9'($urandom_range(0, 255)));
                end
            end else begin
                nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
                for (int n = 0; n < nchars; n++) begin
                    width = $urandom_range(1, 4);
                    case (width)
                        1: lead = 8'($urandom_range(8'h00, 8'h7F));
                        2: begin
                            // now and then a stray continuation as the lead
                            if ($urandom_range(0, 7) == 0)
                                lead = 8'($urandom_range(8'h80, 8'hBF));
                            else
                                lead = 8'($urandom_range(8'hC0, 8'hDF));
                        end
                        3: lead = 8'($urandom_range(8'hE0, 8'hEF));
                        default: lead = 8'($urandom_range(8'hF0, 8'hFF));
                    endcase
                    str_bytes.push_back({1'b0, lead});
                    for (int k = 1; k < width; k++) begin
                        if ($urandom_range(0, 19) == 0)
                            str_bytes.push_back(NO_BYTE);
                        str_bytes.push_back({1'b0, 2'b10, 6'($urandom_range(0, 63))});
                    end
                end
                // cut the tail to leave a partial character
                if ($urandom_range(0, 7) == 0) begin
                    drop = $urandom_range(1, 2);
                    while (drop > 0 && str_bytes.size() > 1) begin
                        void'(str_bytes.pop_back());
                        drop--;
                    end
                end
                if ($urandom_range(0, 9) == 0)
                    str_bytes.push_back(NO_BYTE);
                if ($urandom_range(0, 15) == 0)
                    str_bytes.push_front(NO_BYTE);
            end

            case ($urandom_range(0, 9))
                0, 1:    idx = INDEX_W'($urandom());
                2:       idx = '1;
                default: idx = INDEX_W'($urandom_range(0, nchars + 1));
            endcase
            send_string(idx);
        end

        // ---- Drain ----
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
